// File: hw/rtl/dpts_pkg.sv
// shared types and codes of the dynamic priority task scheduler
`default_nettype none
package dpts_pkg;

    localparam int ID_W   = 8;
    localparam int WORK_W = 16;
    localparam int PRI_W  = 8;
    localparam int STAT_W = 2;
    localparam int LEFT_W = 5;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [STAT_W-1:0] ST_ADDED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RAN   = 2'd2;
    localparam logic [STAT_W-1:0] ST_IDLE  = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   task_id;
        logic [WORK_W-1:0] slices_req;
        logic [PRI_W-1:0]  priority_req;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   ran_task_id;
        logic [WORK_W-1:0] remaining_after;
        logic [PRI_W-1:0]  priority_after;
        logic              finished;
        logic [LEFT_W-1:0] tasks_left;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        logic [WORK_W-1:0] remaining;
        logic [PRI_W-1:0]  pri;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

// File: hw/rtl/dpts_if.sv
// request and response channel interfaces of the scheduler
`default_nettype none
interface dpts_req_if;
    import dpts_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface dpts_rsp_if;
    import dpts_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/dpts_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module dpts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dynamic_priority_task_scheduler.sv
// top level of the dynamic priority task scheduler with aging
//
// i_req carries one request per valid/ready handshake: mode 0 adds a task,
// mode 1 runs one time slice. o_rsp returns exactly one response per
// request, in order. The task table lives in one ram, oldest task at
// address 0 and newest at task count minus one.
// An add, or a tick on an empty table, goes from acceptance straight to the
// done state. A tick reads every live entry through the ram's single read
// port to find the highest priority (ties go to the newest), then writes
// back; a task that finishes is removed instead by moving the newer entries
// down one address each.
// A new request is taken whenever no earlier request is being worked on,
// also while the previous response still waits on o_rsp.
// Reset empties the table at once; no clearing pass is needed.
// When o_rsp stalls, a finished response holds in its register and the
// following one waits internally until the register frees.
`default_nettype none
module dynamic_priority_task_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    dpts_req_if.sink   i_req,
    dpts_rsp_if.source o_rsp
);
    import dpts_pkg::*;

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = $clog2(MAX_TASKS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_iss, n_iss;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_dv, n_dv;
    logic             r_have, n_have;
    t_entry           r_best, n_best;
    logic [CNT_W-1:0] r_best_idx, n_best_idx;
    t_rsp             r_res, n_res;
    t_rsp             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             w_we, w_re;
    logic [IDX_W-1:0] w_waddr, w_raddr;
    t_entry           w_wdata;
    t_entry           w_rdata;
    logic [ENTRY_W-1:0] w_rdata_raw;

    logic [CNT_W+LEFT_W-1:0] w_cnt_ext;
    logic [WORK_W-1:0]       w_rem_dec;
    logic [PRI_W-1:0]        w_pri_dec;
    logic [CNT_W-1:0]        w_last;
    logic                    w_accept;

    dpts_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_TASKS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata_raw)
    );

    assign w_rdata   = t_entry'(w_rdata_raw);
    assign w_cnt_ext = {{LEFT_W{1'b0}}, r_count};
    assign w_rem_dec = (r_best.remaining != '0) ? r_best.remaining - 1'b1 : '0;
    assign w_pri_dec = (r_best.pri != '0) ? r_best.pri - 1'b1 : '0;
    assign w_last    = r_count - 1'b1;
    assign w_accept  = i_req.valid && i_req.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_iss       = r_iss;
        n_ptr       = r_ptr;
        n_dv        = 1'b0;
        n_have      = r_have;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        w_we        = 1'b0;
        w_waddr     = r_count[IDX_W-1:0];
        w_wdata     = r_best;
        w_re        = 1'b0;
        w_raddr     = r_iss[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    if (i_req.data.mode == MODE_ADD) begin
                        if (r_count == CNT_W'(MAX_TASKS)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            n_res.status      = ST_ADDED;
                            w_we              = 1'b1;
                            w_waddr           = r_count[IDX_W-1:0];
                            w_wdata.task_id   = i_req.data.task_id;
                            w_wdata.remaining = i_req.data.slices_req;
                            w_wdata.pri       = i_req.data.priority_req;
                            n_count           = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_res.status = ST_IDLE;
                    end else begin
                        n_iss   = '0;
                        n_have  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_iss < r_count) begin
                    w_re  = 1'b1;
                    n_iss = r_iss + 1'b1;
                    n_ptr = r_iss;
                    n_dv  = 1'b1;
                end
                if (r_dv) begin
                    if (!r_have || (w_rdata.pri >= r_best.pri)) begin
                        n_best     = w_rdata;
                        n_best_idx = r_ptr;
                    end
                    n_have = 1'b1;
                    if (r_ptr == w_last) begin
                        n_state = S_DEC;
                        n_dv    = 1'b0;
                    end
                end
            end
            S_DEC: begin
                n_res                 = '0;
                n_res.status          = ST_RAN;
                n_res.ran_task_id     = r_best.task_id;
                n_res.remaining_after = w_rem_dec;
                n_res.priority_after  = w_pri_dec;
                n_res.finished        = (w_rem_dec == '0);
                if (w_rem_dec == '0) begin
                    n_iss   = r_best_idx + 1'b1;
                    n_state = S_SHIFT;
                end else begin
                    w_we              = 1'b1;
                    w_waddr           = r_best_idx[IDX_W-1:0];
                    w_wdata.task_id   = r_best.task_id;
                    w_wdata.remaining = w_rem_dec;
                    w_wdata.pri       = w_pri_dec;
                    n_state           = S_DONE;
                end
            end
            S_SHIFT: begin
                if (r_iss < r_count) begin
                    w_re  = 1'b1;
                    n_iss = r_iss + 1'b1;
                    n_ptr = r_iss;
                    n_dv  = 1'b1;
                end
                if (r_dv) begin
                    w_we    = 1'b1;
                    w_waddr = IDX_W'(r_ptr - 1'b1);
                    w_wdata = w_rdata;
                end
                if (!r_dv && !(r_iss < r_count)) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out            = r_res;
                    n_out.tasks_left = w_cnt_ext[LEFT_W-1:0];
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss      <= n_iss;
        r_ptr      <= n_ptr;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

endmodule
`default_nettype wire

// File: verif/tb_dynamic_priority_task_scheduler.sv
// self-checking testbench of the dynamic priority task scheduler
module tb_dynamic_priority_task_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import dpts_pkg::*;

    localparam int MAX_TASKS    = 16;
    localparam int ITEMS_PER_PH = 500;
    localparam int NUM_PHASES   = 4;
    localparam int WATCHDOG_MAX = 4000;
    localparam int DRAIN_CYCLES = 2 * MAX_TASKS + 8;
    localparam int SHOWN_MAX    = 10;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dpts_req_if req_if ();
    dpts_rsp_if rsp_if ();

    dynamic_priority_task_scheduler #(
        .MAX_TASKS(MAX_TASKS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // expected task table, newest task in entry 0
    logic [ID_W-1:0]   sched_id  [MAX_TASKS];
    logic [WORK_W-1:0] sched_rem [MAX_TASKS];
    logic [PRI_W-1:0]  sched_pri [MAX_TASKS];
    int                sched_count = 0;

    t_rsp      pending_rsp_q[$];
    t_plan_row plan[$];

    bit   req_typed;
    t_rsp req_typed_rsp;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   mismatches    = 0;
    int   quiet_cycles  = 0;
    bit   moved;
    t_rsp want;

    function automatic t_rsp schedule_step(t_req r);
        t_rsp              res;
        int                i;
        int                pick;
        logic [WORK_W-1:0] rem;
        logic [PRI_W-1:0]  pri;
        res = '0;
        if (r.mode == MODE_ADD) begin
            if (sched_count >= MAX_TASKS) begin
                res.status = ST_FULL;
            end else begin
                for (i = sched_count; i > 0; i--) begin
                    sched_id[i]  = sched_id[i-1];
                    sched_rem[i] = sched_rem[i-1];
                    sched_pri[i] = sched_pri[i-1];
                end
                sched_id[0]  = r.task_id;
                sched_rem[0] = r.slices_req;
                sched_pri[0] = r.priority_req;
                sched_count++;
                res.status = ST_ADDED;
            end
        end else if (sched_count == 0) begin
            res.status = ST_IDLE;
        end else begin
            pick = 0;
            for (i = 1; i < sched_count; i++) begin
                if (sched_pri[i] > sched_pri[pick]) pick = i;
            end
            rem = (sched_rem[pick] != '0) ? sched_rem[pick] - 1'b1 : '0;
            pri = (sched_pri[pick] != '0) ? sched_pri[pick] - 1'b1 : '0;
            res.status          = ST_RAN;
            res.ran_task_id     = sched_id[pick];
            res.remaining_after = rem;
            res.priority_after  = pri;
            res.finished        = (rem == '0);
            if (rem == '0) begin
                for (i = pick; i + 1 < sched_count; i++) begin
                    sched_id[i]  = sched_id[i+1];
                    sched_rem[i] = sched_rem[i+1];
                    sched_pri[i] = sched_pri[i+1];
                end
                sched_count--;
            end else begin
                sched_rem[pick] = rem;
                sched_pri[pick] = pri;
            end
        end
        res.tasks_left = LEFT_W'(sched_count);
        return res;
    endfunction

    function automatic t_req random_task_req(int add_pct);
        t_req r;
        int   sel;
        int   long_live;
        int   i;
        long_live = 0;
        for (i = 0; i < sched_count; i++) begin
            if (sched_rem[i] > 1000) long_live++;
        end
        r.mode    = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_TICK;
        r.task_id = ID_W'($urandom_range(255));
        sel = $urandom_range(99);
        // long jobs are kept few so the table keeps draining
        if (sel < 4) r.slices_req = '0;
        else if (sel < 8 && long_live < 3) r.slices_req = WORK_W'($urandom_range(65535));
        else if (sel < 10 && long_live < 3) r.slices_req = '1;
        else r.slices_req = WORK_W'($urandom_range(8, 1));
        r.priority_req = $urandom_range(1) ? PRI_W'($urandom_range(3))
                                           : PRI_W'($urandom_range(255));
        return r;
    endfunction

    function automatic t_plan_row plan_row(logic m, logic [ID_W-1:0] id,
                                           logic [WORK_W-1:0] work,
                                           logic [PRI_W-1:0] pri, bit typed,
                                           t_rsp rsp);
        t_plan_row row;
        row.req.mode         = m;
        row.req.task_id      = id;
        row.req.slices_req   = work;
        row.req.priority_req = pri;
        row.typed            = typed;
        row.rsp              = rsp;
        return row;
    endfunction

    task automatic drive_req(t_req r, bit typed, t_rsp rsp);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.data   <= r;
        req_typed     <= typed;
        req_typed_rsp <= rsp;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(string what, int unsigned exp_v, int unsigned act_v);
        mismatches++;
        if (mismatches <= SHOWN_MAX) begin
            $display("mismatch in %s: expected %0d, got %0d", what, exp_v, act_v);
        end
    endtask

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        moved = 1'b0;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                want  = schedule_step(req_if.data);
                pending_rsp_q.push_back(req_typed ? req_typed_rsp : want);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                moved = 1'b1;
                if (pending_rsp_q.size() == 0) begin
                    flag_mismatch("response with no request pending, status", 0,
                                  rsp_if.data.status);
                end else begin
                    want = pending_rsp_q.pop_front();
                    if (rsp_if.data.status !== want.status)
                        flag_mismatch("status", want.status, rsp_if.data.status);
                    if (rsp_if.data.ran_task_id !== want.ran_task_id)
                        flag_mismatch("ran_task_id", want.ran_task_id,
                                      rsp_if.data.ran_task_id);
                    if (rsp_if.data.remaining_after !== want.remaining_after)
                        flag_mismatch("remaining_after", want.remaining_after,
                                      rsp_if.data.remaining_after);
                    if (rsp_if.data.priority_after !== want.priority_after)
                        flag_mismatch("priority_after", want.priority_after,
                                      rsp_if.data.priority_after);
                    if (rsp_if.data.finished !== want.finished)
                        flag_mismatch("finished", want.finished, rsp_if.data.finished);
                    if (rsp_if.data.tasks_left !== want.tasks_left)
                        flag_mismatch("tasks_left", want.tasks_left,
                                      rsp_if.data.tasks_left);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no request or response moved in %0d cycles", WATCHDOG_MAX);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int ph;
        int n;
        int add_pct;
        int send_pct [NUM_PHASES];
        int rcv_pct  [NUM_PHASES];
        send_pct = '{0, 77, 0, 10};
        rcv_pct  = '{0, 0, 77, 10};

        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.data   <= '0;
        req_typed     <= 1'b0;
        req_typed_rsp <= '0;

        plan.push_back(plan_row(MODE_TICK, 8'h00, 16'd0, 8'd0, 1'b1,
                                {ST_IDLE, 8'd0, 16'd0, 8'd0, 1'b0, 5'd0}));
        plan.push_back(plan_row(MODE_ADD, 8'h00, 16'd1, 8'd0, 1'b1,
                                {ST_ADDED, 8'd0, 16'd0, 8'd0, 1'b0, 5'd1}));
        // zero priority stays at zero
        plan.push_back(plan_row(MODE_TICK, 8'h00, 16'd0, 8'd0, 1'b1,
                                {ST_RAN, 8'd0, 16'd0, 8'd0, 1'b1, 5'd0}));
        // zero work finishes on its first slice
        plan.push_back(plan_row(MODE_ADD, 8'hff, 16'd0, 8'd255, 1'b1,
                                {ST_ADDED, 8'd0, 16'd0, 8'd0, 1'b0, 5'd1}));
        plan.push_back(plan_row(MODE_TICK, 8'h00, 16'd0, 8'd0, 1'b1,
                                {ST_RAN, 8'd255, 16'd0, 8'd254, 1'b1, 5'd0}));
        // fill the table, duplicate ids and tied priorities included
        plan.push_back(plan_row(MODE_ADD, 8'h42, 16'd2, 8'd7, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h42, 16'd2, 8'd7, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h01, 16'hffff, 8'd255, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h80, 16'd1, 8'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h7f, 16'd3, 8'd7, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'haa, 16'd5, 8'h55, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h02, 16'd1, 8'd1, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h03, 16'd2, 8'd2, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h04, 16'd3, 8'd3, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h05, 16'd4, 8'd4, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h06, 16'd1, 8'd7, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h07, 16'd2, 8'd128, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h08, 16'd1, 8'd127, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h09, 16'd5, 8'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h0a, 16'd2, 8'd7, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'hfe, 16'd1, 8'd6, 1'b0, '0));
        plan.push_back(plan_row(MODE_ADD, 8'h33, 16'd1, 8'd1, 1'b1,
                                {ST_FULL, 8'd0, 16'd0, 8'd0, 1'b0, 5'd16}));
        plan.push_back(plan_row(MODE_TICK, 8'h00, 16'd0, 8'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 8'h00, 16'd0, 8'd0, 1'b0, '0));
        plan.push_back(plan_row(MODE_TICK, 8'h00, 16'd0, 8'd0, 1'b0, '0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) drive_req(plan[k].req, plan[k].typed, plan[k].rsp);

        add_pct = 50;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = send_pct[ph];
            stall_pct     = rcv_pct[ph];
            for (n = 0; n < ITEMS_PER_PH; n++) begin
                // switch at random between draining, balanced and filling bursts
                if (n % 40 == 0) begin
                    case ($urandom_range(2))
                        0: add_pct = 25;
                        1: add_pct = 50;
                        default: add_pct = 75;
                    endcase
                end
                drive_req(random_task_req(add_pct), 1'b0, '0);
            end
        end
        req_if.valid <= 1'b0;

        do begin
            @(posedge i_clk);
        end while (pending_rsp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_rsp_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/dpts_pkg.sv
hw/rtl/dpts_if.sv
hw/rtl/dpts_ram.sv
hw/rtl/dynamic_priority_task_scheduler.sv
verif/tb_dynamic_priority_task_scheduler.sv
